/* src/assert_macros.svh */
// Assertion shorthands, clocked on clk and held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every edge
`define CHK_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold at the edge after ante
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pds_pkg.sv */
package pds_pkg;

  localparam int SUM_W     = 25;   // integral magnitude never exceeds a 24 bit limit
  localparam int GAIN_W    = 16;
  localparam int LIM_W     = 24;
  localparam int TOL_W     = 16;
  localparam int SPD_W     = 15;
  localparam int OUT_W     = 16;
  localparam int COEF_W    = 22;   // multiplier coefficient port, signed
  localparam int CFG_IDX_W = 3;
  localparam int RND_SHIFT = 16;
  localparam int PID_SHIFT = 8;
  localparam int DEADBAND  = 256;  // 1 degree in 1/256 degree

  // wheel travel per encoder turn, Q16
  localparam logic signed [COEF_W-1:0] WHEEL_Q16 = 22'sd1115224;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd256;
  localparam logic [SPD_W-1:0] MAX_RESET = 15'd25600;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN,
    CFG_INTEGRAL_GAIN,
    CFG_DERIVATIVE_GAIN,
    CFG_INTEGRAL_LIMIT,
    CFG_STOP_TOLERANCE,
    CFG_MAX_SPEED,
    CFG_MIN_SPEED,
    CFG_GOAL_DISTANCE
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_RND,
    ST_ERR,
    ST_INT,
    ST_MP,
    ST_MI,
    ST_MD,
    ST_ACC,
    ST_SPD,
    ST_RES,
    ST_EMIT
  } step_t;

  typedef enum logic [1:0] {
    MUL_WHEEL,
    MUL_PROP,
    MUL_INT,
    MUL_DERIV
  } mul_op_t;

  typedef struct packed {
    logic    in_ready;
    logic    mul_en;
    mul_op_t mul_op;
    logic    dist_en;
    logic    err_en;
    logic    int_en;
    logic    acc_first;
    logic    acc_add;
    logic    speed_en;
    logic    res_en;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic in_cmd;
    logic moving;
    logic err_in_tol;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integral_gain;
    logic [GAIN_W-1:0] derivative_gain;
    logic [LIM_W-1:0]  integral_limit;
    logic [TOL_W-1:0]  stop_tolerance;
    logic [SPD_W-1:0]  max_speed;
    logic [SPD_W-1:0]  min_speed;
  } cfg_t;

endpackage

/* src/pds_in_if.sv */
interface pds_in_if #(
  parameter int W = 24
);
  logic                valid;
  logic                ready;
  logic                command;
  logic signed [W-1:0] encoder_position;
  logic signed [W-1:0] heading;

  modport source (output valid, command, encoder_position, heading, input ready);
  modport sink   (input valid, command, encoder_position, heading, output ready);
endinterface

/* src/pds_out_if.sv */
interface pds_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic               brake;
  logic               done_res;

  modport source (output valid, left_speed, right_speed, brake, done_res, input ready);
  modport sink   (input valid, left_speed, right_speed, brake, done_res, output ready);
endinterface

/* src/pid_drive_step_top.sv */
// Straight-drive PID step with integral clamp and heading trim. A start item
// (command 0) clears the integral, loads the last error with goal_distance
// and arms the move; if the goal is already within stop_tolerance it answers
// brake and done at once. A sample item (command 1) turns the encoder position
// into distance (x 3.25*5/3*pi inch per turn, rounded half up), forms the
// error, updates the clamped integral and derivative, and returns the PID sum
// forced into [min_speed, max_speed] by magnitude with half the heading
// (deadband under 1 degree) taken off the left and added to the right. Timing:
// one item at a time. A start item, or a sample with no move armed, goes from
// acceptance straight to the emit step; a live sample is walked by the
// sequencer through one shared multiplier for the wheel scale and the three
// gain products, or leaves after the integral update when it ends the move.
// The next item is taken as soon as the result is handed to the output
// register, so a result left waiting downstream does not hold up input.
// Configuration is taken at any edge with cfg_write high; write only when idle.
`include "assert_macros.svh"

module pid_drive_step_top
  import pds_pkg::*;
#(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [((POSITION_WIDTH > LIM_W) ? POSITION_WIDTH : LIM_W)-1:0] cfg_data,
  pds_in_if.sink               in_ch,
  pds_out_if.source            out_ch
);

  localparam int PW  = POSITION_WIDTH;
  localparam int CW  = (PW > LIM_W) ? PW : LIM_W;
  localparam int EW  = PW + 1;                         // error, last error
  localparam int DW  = EW + 1;                         // derivative, wide compares
  localparam int MW  = (DW > SUM_W) ? DW : SUM_W;      // multiplier data operand
  localparam int PRW = MW + COEF_W;                    // product, accumulator
  localparam int TW  = PRW - PID_SHIFT;                // PID sum after scaling
  localparam int SX  = ((EW > SUM_W) ? EW : SUM_W) + 2; // integral update
  localparam int HW  = PW + 2;                         // speed plus heading trim

  localparam logic signed [EW-1:0]    EMAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0]    EMIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OMAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OMIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic signed [PRW-1:0]   RND_HALF =
    $signed({{(PRW-RND_SHIFT){1'b0}}, 1'b1, {(RND_SHIFT-1){1'b0}}});
  localparam logic signed [PW-1:0]    DB_POS = PW'(DEADBAND);
  localparam logic signed [PW-1:0]    DB_NEG = -DB_POS;

  // --- configuration -------------------------------------------------------
  cfg_t                 cfg;
  logic signed [PW-1:0] goal;

  pds_cfg #(
    .PW (PW),
    .CW (CW)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cfg           (cfg),
    .goal_distance (goal)
  );

  // --- sequencer -----------------------------------------------------------
  ctrl_t ctrl;
  stat_t stat;
  logic  accept;

  // --- state and working registers ----------------------------------------
  logic                     moving;
  logic signed [SUM_W-1:0]  error_sum;
  logic signed [EW-1:0]     prev_err;
  logic signed [PW-1:0]     pos_q;
  logic signed [PW-1:0]     head_q;
  logic signed [EW-1:0]     travel;
  logic signed [EW-1:0]     err;
  logic signed [DW-1:0]     deriv;
  logic signed [PRW-1:0]    acc;
  logic signed [OUT_W-1:0]  speed;
  logic signed [OUT_W-1:0]  res_left;
  logic signed [OUT_W-1:0]  res_right;
  logic                     res_stop;
  logic                     out_valid;
  logic signed [OUT_W-1:0]  out_left;
  logic signed [OUT_W-1:0]  out_right;
  logic                     out_stop;

  assign accept = in_ch.valid && ctrl.in_ready;

  assign stat.in_valid   = in_ch.valid;
  assign stat.in_cmd     = in_ch.command;
  assign stat.moving     = moving;
  assign stat.out_free   = !out_valid || out_ch.ready;

  pds_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // --- shared multiplier ---------------------------------------------------
  logic signed [MW-1:0]     mul_a;
  logic signed [COEF_W-1:0] mul_b;
  logic signed [PRW-1:0]    prod;

  always_comb begin
    unique case (ctrl.mul_op)
      MUL_WHEEL: begin
        mul_a = MW'(pos_q);
        mul_b = WHEEL_Q16;
      end
      MUL_PROP: begin
        mul_a = MW'(err);
        mul_b = $signed({{(COEF_W-GAIN_W){1'b0}}, cfg.prop_gain});
      end
      MUL_INT: begin
        mul_a = MW'(error_sum);
        mul_b = $signed({{(COEF_W-GAIN_W){1'b0}}, cfg.integral_gain});
      end
      MUL_DERIV: begin
        mul_a = MW'(deriv);
        mul_b = $signed({{(COEF_W-GAIN_W){1'b0}}, cfg.derivative_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pds_mul #(
    .AW (MW),
    .BW (COEF_W)
  ) u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // --- distance: round half up, drop 16 fraction bits, saturate -------------
  logic signed [PRW-1:0] rnd_sum;
  logic signed [PRW-1:0] dist_full;
  logic                  dist_fits;
  logic signed [EW-1:0]  dist_sat;

  assign rnd_sum   = prod + RND_HALF;
  assign dist_full = rnd_sum >>> RND_SHIFT;
  assign dist_fits = (&dist_full[PRW-1:EW-1]) | ~(|dist_full[PRW-1:EW-1]);
  assign dist_sat  = dist_fits ? dist_full[EW-1:0] : (dist_full[PRW-1] ? EMIN : EMAX);

  // --- error and tolerance ------------------------------------------------
  logic signed [DW-1:0] err_full;
  logic                 err_fits;
  logic signed [EW-1:0] err_sat;
  logic signed [DW-1:0] tol_s;
  logic signed [DW-1:0] err_x;
  logic signed [DW-1:0] goal_x;
  logic                 goal_big;

  assign err_full = DW'(goal) - DW'(travel);
  assign err_fits = (&err_full[DW-1:EW-1]) | ~(|err_full[DW-1:EW-1]);
  assign err_sat  = err_fits ? err_full[EW-1:0] : (err_full[DW-1] ? EMIN : EMAX);

  assign tol_s           = $signed({{(DW-TOL_W){1'b0}}, cfg.stop_tolerance});
  assign err_x           = DW'(err);
  assign stat.err_in_tol = (err_x <= tol_s) && (err_x >= -tol_s);
  assign goal_x          = DW'(goal);
  assign goal_big        = (goal_x > tol_s) || (goal_x < -tol_s);

  // --- integral clamp and derivative ---------------------------------------
  logic signed [SX-1:0]    sum_raw;
  logic signed [SX-1:0]    lim_s;
  logic signed [SX-1:0]    sum_clamp;
  logic signed [DW-1:0]    deriv_next;

  assign sum_raw = SX'(error_sum) + SX'(err);
  assign lim_s   = $signed({{(SX-LIM_W){1'b0}}, cfg.integral_limit});

  always_comb begin
    priority if (sum_raw > lim_s) begin
      sum_clamp = lim_s;
    end else if (sum_raw < -lim_s) begin
      sum_clamp = -lim_s;
    end else begin
      sum_clamp = sum_raw;
    end
  end

  assign deriv_next = DW'(err) - DW'(prev_err);

  // --- speed band: max test first, a zero sum stays zero --------------------
  logic signed [TW-1:0]    total;
  logic signed [TW-1:0]    max_s;
  logic signed [TW-1:0]    min_s;
  logic signed [OUT_W-1:0] speed_next;

  assign total = acc[PRW-1:PID_SHIFT];
  assign max_s = $signed({{(TW-SPD_W){1'b0}}, cfg.max_speed});
  assign min_s = $signed({{(TW-SPD_W){1'b0}}, cfg.min_speed});

  always_comb begin
    priority if (total > max_s) begin
      speed_next = OUT_W'(max_s);
    end else if (total < -max_s) begin
      speed_next = OUT_W'(-max_s);
    end else if (total > 0 && total < min_s) begin
      speed_next = OUT_W'(min_s);
    end else if (total < 0 && total > -min_s) begin
      speed_next = OUT_W'(-min_s);
    end else begin
      speed_next = OUT_W'(total);
    end
  end

  // --- heading trim and side saturation ------------------------------------
  logic signed [PW-1:0] head_db;
  logic signed [PW-1:0] half;
  logic signed [HW-1:0] left_full;
  logic signed [HW-1:0] right_full;
  logic                 left_fits;
  logic                 right_fits;
  logic signed [OUT_W-1:0] left_sat;
  logic signed [OUT_W-1:0] right_sat;

  assign head_db    = (head_q > DB_NEG && head_q < DB_POS) ? '0 : head_q;
  assign half       = head_db >>> 1;
  assign left_full  = HW'(speed) - HW'(half);
  assign right_full = HW'(speed) + HW'(half);
  assign left_fits  = (&left_full[HW-1:OUT_W-1]) | ~(|left_full[HW-1:OUT_W-1]);
  assign right_fits = (&right_full[HW-1:OUT_W-1]) | ~(|right_full[HW-1:OUT_W-1]);
  assign left_sat   = left_fits ? left_full[OUT_W-1:0] :
                      (left_full[HW-1] ? OMIN : OMAX);
  assign right_sat  = right_fits ? right_full[OUT_W-1:0] :
                      (right_full[HW-1] ? OMIN : OMAX);

  // --- control state -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      moving    <= 1'b0;
      error_sum <= '0;
      prev_err  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept && in_ch.command == CMD_START) begin
        error_sum <= '0;
        prev_err  <= EW'(goal);
        moving    <= goal_big;
      end
      if (ctrl.int_en) begin
        error_sum <= sum_clamp[SUM_W-1:0];
        prev_err  <= err;
        if (stat.err_in_tol) begin
          moving <= 1'b0;
        end
      end
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --- datapath registers --------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q     <= in_ch.encoder_position;
      head_q    <= in_ch.heading;
      res_left  <= '0;
      res_right <= '0;
      // start: stop only if the goal is already met; idle sample: stop
      res_stop  <= (in_ch.command == CMD_START) ? !goal_big : 1'b1;
    end
    if (ctrl.dist_en) begin
      travel <= dist_sat;
    end
    if (ctrl.err_en) begin
      err <= err_sat;
    end
    if (ctrl.int_en) begin
      deriv <= deriv_next;
      if (stat.err_in_tol) begin
        res_left  <= '0;
        res_right <= '0;
        res_stop  <= 1'b1;
      end
    end
    if (ctrl.acc_first) begin
      acc <= prod;
    end else if (ctrl.acc_add) begin
      acc <= acc + prod;
    end
    if (ctrl.speed_en) begin
      speed <= speed_next;
    end
    if (ctrl.res_en) begin
      res_left  <= left_sat;
      res_right <= right_sat;
      res_stop  <= 1'b0;
    end
    if (ctrl.out_load) begin
      out_left  <= res_left;
      out_right <= res_right;
      out_stop  <= res_stop;
    end
  end

  assign in_ch.ready        = ctrl.in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.left_speed  = out_left;
  assign out_ch.right_speed = out_right;
  assign out_ch.brake       = out_stop;
  assign out_ch.done_res    = out_stop;

  // --- checks --------------------------------------------------------------
  `CHK_NEXT(a_busy_after_accept, accept, !in_ch.ready, "item taken while busy")
  `CHK_HOLDS(a_stop_zero_speed,
             !(out_valid && out_stop) || (out_left == '0 && out_right == '0),
             "brake with nonzero speed")
  `CHK_NEXT(a_done_disarms, ctrl.int_en && stat.err_in_tol, !moving,
            "move still armed after reaching tolerance")
  `CHK_NEXT(a_integral_clamped, ctrl.int_en,
            (SX'(error_sum) <= lim_s) && (SX'(error_sum) >= -lim_s),
            "integral outside its limit")

endmodule

/* src/pds_cfg.sv */
module pds_cfg
  import pds_pkg::*;
#(
  parameter int PW = 24,
  parameter int CW = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_data,
  output cfg_t                 cfg,
  output logic signed [PW-1:0] goal_distance
);

  cfg_idx_t idx;
  assign idx = cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain       <= '0;
      cfg.integral_gain   <= '0;
      cfg.derivative_gain <= '0;
      cfg.integral_limit  <= '0;
      cfg.stop_tolerance  <= TOL_RESET;
      cfg.max_speed       <= MAX_RESET;
      cfg.min_speed       <= '0;
      goal_distance       <= '0;
    end else if (cfg_write) begin
      unique case (idx)
        CFG_PROP_GAIN:       cfg.prop_gain       <= cfg_data[GAIN_W-1:0];
        CFG_INTEGRAL_GAIN:   cfg.integral_gain   <= cfg_data[GAIN_W-1:0];
        CFG_DERIVATIVE_GAIN: cfg.derivative_gain <= cfg_data[GAIN_W-1:0];
        CFG_INTEGRAL_LIMIT:  cfg.integral_limit  <= cfg_data[LIM_W-1:0];
        CFG_STOP_TOLERANCE:  cfg.stop_tolerance  <= cfg_data[TOL_W-1:0];
        CFG_MAX_SPEED:       cfg.max_speed       <= cfg_data[SPD_W-1:0];
        CFG_MIN_SPEED:       cfg.min_speed       <= cfg_data[SPD_W-1:0];
        CFG_GOAL_DISTANCE:   goal_distance       <= $signed(cfg_data[PW-1:0]);
      endcase
    end
  end

endmodule

/* src/pds_mul.sv */
// Shared signed multiplier, product registered.
module pds_mul #(
  parameter int AW = 25,
  parameter int BW = 22
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= (AW+BW)'(a) * (AW+BW)'(b);
    end
  end

endmodule

/* src/pds_seq.sv */
module pds_seq
  import pds_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  step_t step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl      = '0;
    ctrl.mul_op = MUL_WHEEL;
    step_next = step;
    unique case (step)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (stat.in_valid) begin
          // start items and samples with no move armed answer at once
          if (stat.in_cmd == CMD_START || !stat.moving) begin
            step_next = ST_EMIT;
          end else begin
            step_next = ST_DIST;
          end
        end
      end
      ST_DIST: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MUL_WHEEL;
        step_next   = ST_RND;
      end
      ST_RND: begin
        ctrl.dist_en = 1'b1;
        step_next    = ST_ERR;
      end
      ST_ERR: begin
        ctrl.err_en = 1'b1;
        step_next   = ST_INT;
      end
      ST_INT: begin
        ctrl.int_en = 1'b1;
        step_next   = stat.err_in_tol ? ST_EMIT : ST_MP;
      end
      ST_MP: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MUL_PROP;
        step_next   = ST_MI;
      end
      ST_MI: begin
        ctrl.acc_first = 1'b1;
        ctrl.mul_en    = 1'b1;
        ctrl.mul_op    = MUL_INT;
        step_next      = ST_MD;
      end
      ST_MD: begin
        ctrl.acc_add = 1'b1;
        ctrl.mul_en  = 1'b1;
        ctrl.mul_op  = MUL_DERIV;
        step_next    = ST_ACC;
      end
      ST_ACC: begin
        ctrl.acc_add = 1'b1;
        step_next    = ST_SPD;
      end
      ST_SPD: begin
        ctrl.speed_en = 1'b1;
        step_next     = ST_RES;
      end
      ST_RES: begin
        ctrl.res_en = 1'b1;
        step_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          step_next     = ST_IDLE;
        end
      end
      default: begin
        step_next = ST_IDLE;
      end
    endcase
  end

endmodule
